FILE: rtl/core/imu_osbf_pkg.sv
// Shared constants, field widths, configuration layout and the command and
// status bundles that pass between the controller and the datapath.
// No dependencies.
package imu_osbf_pkg;

    // Fixed sizing of the stores and the sample width.
    localparam int WINDOW_MAX  = 16;
    localparam int CAL_MAX     = 128;
    localparam int SAMPLE_BITS = 16;
    localparam int SB          = SAMPLE_BITS;
    localparam int SPEED_W     = 16;
    localparam int N_AXES      = 6;
    localparam int N_GYRO      = 3;
    localparam int N_ACCEL     = 3;

    localparam int LOG_W   = $clog2(WINDOW_MAX);
    localparam int LOG_C   = $clog2(CAL_MAX);
    localparam int WCNT_W  = LOG_W + 1;
    localparam int CCNT_W  = LOG_C + 1;

    // Statistics widths.
    localparam int SUM_W   = SB + LOG_W;
    localparam int SQ_W    = 2 * SB + LOG_W - 1;
    localparam int D_W     = SB + LOG_W + 2;
    localparam int DM_W    = D_W - 1;
    localparam int D2_W    = 2 * DM_W;
    localparam int SM_W    = SUM_W;
    localparam int S2_W    = 2 * SM_W;
    localparam int WQ_W    = SQ_W + WCNT_W;
    localparam int VAR_W   = WQ_W;
    localparam int K_W     = 8;
    localparam int K2_W    = 2 * K_W;
    localparam int PROD_W  = VAR_W + K2_W;
    localparam int LHS_W   = D2_W + 8;
    localparam int CMP_W   = (LHS_W > PROD_W) ? LHS_W : PROD_W;
    localparam int CSUM_W  = SB + LOG_C;

    // Shared divider sizing.
    localparam int DIVN_W  = CSUM_W;
    localparam int DIVD_W  = CCNT_W;
    localparam int DCNT_W  = $clog2(DIVN_W + 1);
    localparam int DIDX_W  = $clog2(N_AXES);

    // Configuration port.
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    typedef enum logic [2:0] {
        REG_WIN_LEN          = 3'd0,
        REG_SIGMA_FACTOR     = 3'd1,
        REG_AVERAGE_SIZE     = 3'd2,
        REG_STATIONARY_SPEED = 3'd3,
        REG_CALIBRATION_SIZE = 3'd4,
        REG_AUTO_CALIBRATION = 3'd5
    } t_reg;

    typedef logic signed [SB-1:0] t_smp;

    typedef struct packed {
        logic [4:0]  win_len;
        logic [7:0]  sigma_factor;
        logic [4:0]  average_size;
        logic [14:0] stationary_speed;
        logic [7:0]  calibration_size;
        logic        auto_calibration;
    } t_cfg;

    // Commands from the controller.
    typedef struct packed {
        logic load;
        logic speed_upd;
        logic rd;
        logic acc_win;
        logic test1;
        logic test2;
        logic test3;
        logic test4;
        logic commit;
        logic acc_avg;
        logic div_start;
        logic div_store;
        logic div_cal;
        logic cal_push;
        logic acc_cal;
        logic bias_set;
        logic out_load;
    } t_cmd;

    // Status back to the controller.
    typedef struct packed {
        logic op;
        logic need_test;
        logic win_last;
        logic avg_go;
        logic avg_last;
        logic cal_go;
        logic cal_full;
        logic cal_last;
        logic div_done;
        logic avg_div_last;
        logic cal_div_last;
    } t_stat;

endpackage

FILE: rtl/core/imu_osbf_div.sv
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on imu_osbf_pkg.
module imu_osbf_div
    import imu_osbf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIVN_W-1:0] i_dividend,
    input  logic [DIVD_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DIVN_W-1:0] o_quotient
);

    logic [DIVN_W-1:0] r_quo;
    logic [DIVD_W-1:0] r_rem;
    logic [DIVD_W-1:0] r_dvs;
    logic [DCNT_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DIVD_W:0]   trial;

    // Next partial remainder with the next dividend bit shifted in.
    assign trial = {r_rem, r_quo[DIVN_W-1]};

    // Iteration control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(DIVN_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Shift and subtract.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_dvs}) begin
                r_rem <= DIVD_W'(trial - {1'b0, r_dvs});
                r_quo <= {r_quo[DIVN_W-2:0], 1'b1};
            end else begin
                r_rem <= trial[DIVD_W-1:0];
                r_quo <= {r_quo[DIVN_W-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: rtl/core/imu_osbf_dp.sv
// Datapath: sample and calibration rings, window statistics, outlier test,
// smoothing and bias sums, bias correction. Depends on imu_osbf_pkg, imu_osbf_div.
module imu_osbf_dp
    import imu_osbf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  t_cmd                  i_cmd,
    input  logic [N_AXES*SB+SPEED_W-1:0] i_tdata,
    input  logic                  i_tuser,
    output t_stat                 o_stat,
    output logic [N_AXES*SB-1:0]  o_out_data,
    output logic [1:0]            o_out_user
);

    // Architectural state.
    t_smp              r_v     [N_AXES];
    t_smp              r_last  [N_AXES];
    t_smp              r_bias  [N_GYRO];
    logic [WCNT_W-1:0] r_scnt;
    logic [LOG_W-1:0]  r_shead;
    logic              r_have_good;
    logic [CCNT_W-1:0] r_bcnt;
    logic [LOG_C-1:0]  r_bhead;
    logic              r_bias_valid;
    logic [14:0]       r_spd;
    logic              r_spd_seen;

    // Working registers.
    logic [WCNT_W-1:0] r_n;
    logic [CCNT_W-1:0] r_idx;
    logic [DIDX_W-1:0] r_didx;
    logic              r_outlier;
    logic              r_dneg;
    logic [K2_W-1:0]   r_k2;
    logic signed [SUM_W-1:0]  r_s    [N_ACCEL];
    logic [SQ_W-1:0]          r_q    [N_ACCEL];
    logic signed [D_W-1:0]    r_d    [N_ACCEL];
    logic [S2_W-1:0]          r_s2   [N_ACCEL];
    logic [WQ_W-1:0]          r_wq   [N_ACCEL];
    logic [D2_W-1:0]          r_d2   [N_ACCEL];
    logic [VAR_W-1:0]         r_var  [N_ACCEL];
    logic [PROD_W-1:0]        r_prod [N_ACCEL];
    logic signed [SUM_W-1:0]  r_asum [N_AXES];
    logic signed [CSUM_W-1:0] r_csum [N_GYRO];

    // Memories.
    logic [N_AXES*SB-1:0] smem [WINDOW_MAX];
    logic [N_GYRO*SB-1:0] bmem [CAL_MAX];
    logic [N_AXES*SB-1:0] r_srd;
    logic [N_GYRO*SB-1:0] r_brd;

    // Combinational helpers.
    logic [WCNT_W-1:0] w_eff;
    logic [CCNT_W-1:0] c_eff;
    logic [4:0]        m_eff;
    logic [WCNT_W-1:0] n_cur;
    logic [WCNT_W-1:0] n_push;
    logic [CCNT_W-1:0] bn_cur;
    logic [CCNT_W-1:0] bn_push;
    logic [LOG_W-1:0]  saddr;
    logic [LOG_C-1:0]  baddr;
    logic [N_AXES*SB-1:0] swdata;
    logic [N_GYRO*SB-1:0] bwdata;
    logic signed [SPEED_W-1:0] spd_in;
    logic [SPEED_W-1:0]        spd_mag;
    t_smp                      acc_x   [N_AXES];
    t_smp                      cal_x   [N_GYRO];
    logic signed [2*SB-1:0]    sq      [N_ACCEL];
    logic signed [D_W-1:0]     wx      [N_ACCEL];
    logic [SM_W-1:0]           smag    [N_ACCEL];
    logic [DM_W-1:0]           dmag    [N_ACCEL];
    logic [N_ACCEL-1:0]        fail;
    logic signed [CSUM_W-1:0]  div_sum;
    logic [DIVN_W-1:0]         div_num;
    logic [DIVD_W-1:0]         div_den;
    logic                      div_done;
    logic [DIVN_W-1:0]         div_quo;
    t_smp                      div_res;
    logic signed [SB:0]        bdiff   [N_GYRO];

    // Effective sizes.
    always_comb begin
        if (i_cfg.win_len == '0) begin
            w_eff = WCNT_W'(1);
        end else if (32'(i_cfg.win_len) > WINDOW_MAX) begin
            w_eff = WCNT_W'(WINDOW_MAX);
        end else begin
            w_eff = WCNT_W'(i_cfg.win_len);
        end
        if (i_cfg.calibration_size == '0) begin
            c_eff = CCNT_W'(1);
        end else if (32'(i_cfg.calibration_size) > CAL_MAX) begin
            c_eff = CCNT_W'(CAL_MAX);
        end else begin
            c_eff = CCNT_W'(i_cfg.calibration_size);
        end
        m_eff   = (i_cfg.average_size == '0) ? 5'd1 : i_cfg.average_size;
        n_cur   = (r_scnt < w_eff) ? r_scnt : w_eff;
        n_push  = (r_n + 1'b1 > w_eff) ? w_eff : r_n + 1'b1;
        bn_cur  = (r_bcnt < c_eff) ? r_bcnt : c_eff;
        bn_push = (bn_cur + 1'b1 > c_eff) ? c_eff : bn_cur + 1'b1;
    end

    // Newest-first read addresses.
    assign saddr = r_shead - 1'b1 - r_idx[LOG_W-1:0];
    assign baddr = r_bhead - 1'b1 - r_idx[LOG_C-1:0];

    // Status to the controller.
    always_comb begin
        o_stat.op           = i_tuser;
        o_stat.need_test    = (r_scnt >= w_eff);
        o_stat.win_last     = (r_idx == CCNT_W'(w_eff));
        o_stat.avg_go       = (32'(r_n) >= 32'(m_eff));
        o_stat.avg_last     = (32'(r_idx) == 32'(m_eff));
        o_stat.cal_go       = i_cfg.auto_calibration && r_spd_seen
                              && (r_spd < i_cfg.stationary_speed);
        o_stat.cal_full     = (r_bcnt >= c_eff);
        o_stat.cal_last     = (r_idx == c_eff);
        o_stat.div_done     = div_done;
        o_stat.avg_div_last = (r_didx == DIDX_W'(N_AXES - 1));
        o_stat.cal_div_last = (r_didx == DIDX_W'(N_GYRO - 1));
    end

    // Per-axis arithmetic.
    always_comb begin
        for (int a = 0; a < N_AXES; a++) begin
            swdata[a*SB +: SB] = r_v[a];
            acc_x[a]           = t_smp'(r_srd[a*SB +: SB]);
        end
        for (int g = 0; g < N_GYRO; g++) begin
            bwdata[g*SB +: SB] = r_v[N_ACCEL+g];
            cal_x[g]           = t_smp'(r_brd[g*SB +: SB]);
        end
        for (int a = 0; a < N_ACCEL; a++) begin
            sq[a]   = acc_x[a] * acc_x[a];
            wx[a]   = D_W'(signed'({1'b0, w_eff})) * D_W'(r_v[a]);
            smag[a] = r_s[a][SUM_W-1] ? SM_W'(-r_s[a]) : SM_W'(r_s[a]);
            dmag[a] = r_d[a][D_W-1] ? DM_W'(-r_d[a]) : DM_W'(r_d[a]);
            fail[a] = CMP_W'({r_d2[a], 8'd0}) > CMP_W'(r_prod[a]);
        end
    end

    // Speed magnitude with saturation of the most negative value.
    assign spd_in  = signed'(i_tdata[N_AXES*SB +: SPEED_W]);
    assign spd_mag = spd_in[SPEED_W-1] ? SPEED_W'(-spd_in) : SPEED_W'(spd_in);

    // Divider operands and signed result.
    always_comb begin
        if (i_cmd.div_cal) begin
            div_sum = r_csum[r_didx[1:0]];
            div_den = c_eff;
        end else begin
            div_sum = CSUM_W'(r_asum[r_didx]);
            div_den = DIVD_W'(m_eff);
        end
        div_num = div_sum[CSUM_W-1] ? DIVN_W'(-div_sum) : DIVN_W'(div_sum);
        div_res = r_dneg ? -t_smp'(div_quo[SB-1:0]) : t_smp'(div_quo[SB-1:0]);
    end

    imu_osbf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_num),
        .i_divisor  (div_den),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Sample ring, one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && !r_outlier) begin
            smem[r_shead] <= swdata;
        end
        r_srd <= smem[saddr];
    end

    // Calibration ring.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cal_push) begin
            bmem[r_bhead] <= bwdata;
        end
        r_brd <= bmem[baddr];
    end

    // Control state of the filter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scnt       <= '0;
            r_shead      <= '0;
            r_have_good  <= 1'b0;
            r_bcnt       <= '0;
            r_bhead      <= '0;
            r_bias_valid <= 1'b0;
            r_spd        <= '0;
            r_spd_seen   <= 1'b0;
            r_idx        <= '0;
            r_didx       <= '0;
            r_outlier    <= 1'b0;
        end else begin
            if (i_cmd.speed_upd) begin
                r_spd      <= spd_mag[SPEED_W-1] ? 15'h7fff : spd_mag[14:0];
                r_spd_seen <= 1'b1;
            end
            if (i_cmd.load || i_cmd.commit || i_cmd.cal_push) begin
                r_idx  <= '0;
                r_didx <= '0;
            end else if (i_cmd.rd) begin
                r_idx <= r_idx + 1'b1;
            end else if (i_cmd.div_store) begin
                r_didx <= r_didx + 1'b1;
            end
            if (i_cmd.load) begin
                r_outlier <= 1'b0;
            end
            if (i_cmd.test4) begin
                r_outlier <= |fail;
            end
            if (i_cmd.commit && !r_outlier) begin
                r_shead     <= r_shead + 1'b1;
                r_scnt      <= n_push;
                r_have_good <= 1'b1;
            end
            if (i_cmd.cal_push) begin
                r_bhead <= r_bhead + 1'b1;
                r_bcnt  <= bn_push;
            end
            if (i_cmd.bias_set) begin
                r_bias_valid <= 1'b1;
            end
        end
    end

    // Last good value and biases (reset to zero).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < N_AXES; a++) begin
                r_last[a] <= '0;
            end
            for (int g = 0; g < N_GYRO; g++) begin
                r_bias[g] <= '0;
            end
        end else begin
            if (i_cmd.commit && !r_outlier) begin
                for (int a = 0; a < N_AXES; a++) begin
                    r_last[a] <= r_v[a];
                end
            end
            if (i_cmd.div_store && i_cmd.div_cal) begin
                r_bias[r_didx[1:0]] <= div_res;
            end
        end
    end

    // Working payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int a = 0; a < N_AXES; a++) begin
                r_v[a] <= t_smp'(i_tdata[a*SB +: SB]);
            end
            for (int a = 0; a < N_ACCEL; a++) begin
                r_s[a] <= '0;
                r_q[a] <= '0;
            end
            r_n  <= n_cur;
            r_k2 <= K2_W'(i_cfg.sigma_factor) * K2_W'(i_cfg.sigma_factor);
        end
        if (i_cmd.acc_win) begin
            for (int a = 0; a < N_ACCEL; a++) begin
                r_s[a] <= r_s[a] + SUM_W'(acc_x[a]);
                r_q[a] <= r_q[a] + SQ_W'(unsigned'(sq[a]));
            end
        end
        if (i_cmd.test1) begin
            for (int a = 0; a < N_ACCEL; a++) begin
                r_d[a]  <= wx[a] - D_W'(r_s[a]);
                r_s2[a] <= S2_W'(smag[a]) * S2_W'(smag[a]);
                r_wq[a] <= WQ_W'(w_eff) * WQ_W'(r_q[a]);
            end
        end
        if (i_cmd.test2) begin
            for (int a = 0; a < N_ACCEL; a++) begin
                r_d2[a]  <= D2_W'(dmag[a]) * D2_W'(dmag[a]);
                r_var[a] <= (r_wq[a] > VAR_W'(r_s2[a]))
                            ? r_wq[a] - VAR_W'(r_s2[a]) : '0;
            end
        end
        if (i_cmd.test3) begin
            for (int a = 0; a < N_ACCEL; a++) begin
                r_prod[a] <= PROD_W'(r_var[a]) * PROD_W'(r_k2);
            end
        end
        if (i_cmd.commit) begin
            if (!r_outlier) begin
                r_n <= n_push;
            end else if (r_have_good) begin
                for (int a = 0; a < N_AXES; a++) begin
                    r_v[a] <= r_last[a];
                end
            end
            for (int a = 0; a < N_AXES; a++) begin
                r_asum[a] <= '0;
            end
        end
        if (i_cmd.acc_avg) begin
            for (int a = 0; a < N_AXES; a++) begin
                r_asum[a] <= r_asum[a] + SUM_W'(acc_x[a]);
            end
        end
        if (i_cmd.cal_push) begin
            for (int g = 0; g < N_GYRO; g++) begin
                r_csum[g] <= '0;
            end
        end
        if (i_cmd.acc_cal) begin
            for (int g = 0; g < N_GYRO; g++) begin
                r_csum[g] <= r_csum[g] + CSUM_W'(cal_x[g]);
            end
        end
        if (i_cmd.div_start) begin
            r_dneg <= div_sum[CSUM_W-1];
        end
        if (i_cmd.div_store && !i_cmd.div_cal) begin
            r_v[r_didx] <= div_res;
        end
    end

    // Result: accel as is, gyro with saturating bias removal once a bias is valid.
    always_comb begin
        for (int a = 0; a < N_ACCEL; a++) begin
            o_out_data[a*SB +: SB] = r_v[a];
        end
        for (int g = 0; g < N_GYRO; g++) begin
            bdiff[g] = (SB+1)'(r_v[N_ACCEL+g]) - (SB+1)'(r_bias[g]);
            if (!r_bias_valid) begin
                o_out_data[(N_ACCEL+g)*SB +: SB] = r_v[N_ACCEL+g];
            end else if (bdiff[g][SB] != bdiff[g][SB-1]) begin
                o_out_data[(N_ACCEL+g)*SB +: SB] =
                    bdiff[g][SB] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
            end else begin
                o_out_data[(N_ACCEL+g)*SB +: SB] = bdiff[g][SB-1:0];
            end
        end
        o_out_user = {r_bias_valid, r_outlier};
    end

endmodule

FILE: rtl/core/imu_osbf_ctrl.sv
// Controller state machine sequencing window statistics, outlier test,
// smoothing, calibration and result hand-off. Depends on imu_osbf_pkg.
module imu_osbf_ctrl
    import imu_osbf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  logic  i_out_free,
    input  t_stat i_stat,
    output logic  o_ready,
    output t_cmd  o_cmd
);

    typedef enum logic [19:0] {
        ST_IDLE    = 20'h00001,
        ST_W_RD    = 20'h00002,
        ST_W_ACC   = 20'h00004,
        ST_T1      = 20'h00008,
        ST_T2      = 20'h00010,
        ST_T3      = 20'h00020,
        ST_T4      = 20'h00040,
        ST_COMMIT  = 20'h00080,
        ST_A_CHK   = 20'h00100,
        ST_A_RD    = 20'h00200,
        ST_A_ACC   = 20'h00400,
        ST_A_DIV   = 20'h00800,
        ST_A_DWAIT = 20'h01000,
        ST_C_CHK   = 20'h02000,
        ST_C_FULL  = 20'h04000,
        ST_C_RD    = 20'h08000,
        ST_C_ACC   = 20'h10000,
        ST_C_DIV   = 20'h20000,
        ST_C_DWAIT = 20'h40000,
        ST_OUT     = 20'h80000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_stat.op) begin
                        o_cmd.speed_upd = 1'b1;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state = i_stat.need_test ? ST_W_RD : ST_COMMIT;
                    end
                end
            end
            ST_W_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_W_ACC;
            end
            ST_W_ACC: begin
                o_cmd.acc_win = 1'b1;
                n_state = i_stat.win_last ? ST_T1 : ST_W_RD;
            end
            ST_T1: begin
                o_cmd.test1 = 1'b1;
                n_state = ST_T2;
            end
            ST_T2: begin
                o_cmd.test2 = 1'b1;
                n_state = ST_T3;
            end
            ST_T3: begin
                o_cmd.test3 = 1'b1;
                n_state = ST_T4;
            end
            ST_T4: begin
                o_cmd.test4 = 1'b1;
                n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state = ST_A_CHK;
            end
            ST_A_CHK: begin
                n_state = i_stat.avg_go ? ST_A_RD : ST_C_CHK;
            end
            ST_A_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_A_ACC;
            end
            ST_A_ACC: begin
                o_cmd.acc_avg = 1'b1;
                n_state = i_stat.avg_last ? ST_A_DIV : ST_A_RD;
            end
            ST_A_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state = ST_A_DWAIT;
            end
            ST_A_DWAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.div_store = 1'b1;
                    n_state = i_stat.avg_div_last ? ST_C_CHK : ST_A_DIV;
                end
            end
            ST_C_CHK: begin
                if (i_stat.cal_go) begin
                    o_cmd.cal_push = 1'b1;
                    n_state = ST_C_FULL;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_C_FULL: begin
                n_state = i_stat.cal_full ? ST_C_RD : ST_OUT;
            end
            ST_C_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_C_ACC;
            end
            ST_C_ACC: begin
                o_cmd.acc_cal = 1'b1;
                n_state = i_stat.cal_last ? ST_C_DIV : ST_C_RD;
            end
            ST_C_DIV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_cal   = 1'b1;
                n_state = ST_C_DWAIT;
            end
            ST_C_DWAIT: begin
                o_cmd.div_cal = 1'b1;
                if (i_stat.div_done) begin
                    o_cmd.div_store = 1'b1;
                    if (i_stat.cal_div_last) begin
                        o_cmd.bias_set = 1'b1;
                        n_state = ST_OUT;
                    end else begin
                        n_state = ST_C_DIV;
                    end
                end
            end
            ST_OUT: begin
                if (i_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/imu_outlier_smooth_bias_filter.sv
// Top level: configuration registers, controller, datapath and result register.
// Depends on imu_osbf_pkg, imu_osbf_ctrl, imu_osbf_dp.
//
//  Channel   Direction  Handshake                  Contents
//  s_axis    in         tvalid / tready            IMU sample or velocity update
//  m_axis    out        tvalid / tready            filtered sample, flags
//  apb       in         psel, penable, pwrite      six configuration registers
//
// An IMU sample passes accept, commit, the two checks and output, plus the window
// reads and test steps once the window is full, M reads and six divisions when
// at least M samples are stored, a ring-full check when a gyro sample is stored,
// and C reads and three divisions when the calibration ring is then full. Sums
// read and add one ring entry at a time; each mean uses one shared 23-step serial
// divider. An unread result stalls the next sample before output.
// Reset is synchronous and clears all control state; no ring clearing is needed.
// A finished result waits in the output register while the next beat is accepted.
module imu_outlier_smooth_bias_filter
    import imu_osbf_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Fields from bit 0: accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, speed.
    input  logic [N_AXES*SB+SPEED_W-1:0] i_s_axis_tdata,
    // Fields from bit 0: op.
    input  logic [0:0]                   i_s_axis_tuser,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    // Fields from bit 0: out_accel_x/y/z, out_gyro_x/y/z.
    output logic [N_AXES*SB-1:0]         o_m_axis_tdata,
    // Fields from bit 0: was_outlier, calibrated.
    output logic [1:0]                   o_m_axis_tuser,
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ADDR_W-1:0]            paddr,
    input  logic [DATA_W-1:0]            pwdata,
    output logic [DATA_W-1:0]            prdata,
    output logic                         pready
);

    t_cfg                 r_cfg;
    t_cmd                 cmd;
    t_stat                stat;
    t_reg                 reg_sel;
    logic [N_AXES*SB-1:0] res_data;
    logic [1:0]           res_user;
    logic                 r_out_valid;
    logic [N_AXES*SB-1:0] r_out_data;
    logic [1:0]           r_out_user;
    logic                 out_free;

    assign pready  = 1'b1;
    assign reg_sel = t_reg'(paddr[4:2]);

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.win_len          <= 5'd10;
            r_cfg.sigma_factor     <= 8'd48;
            r_cfg.average_size     <= 5'd3;
            r_cfg.stationary_speed <= 15'd26;
            r_cfg.calibration_size <= 8'd100;
            r_cfg.auto_calibration <= 1'b1;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_sel)
                REG_WIN_LEN:          r_cfg.win_len          <= pwdata[4:0];
                REG_SIGMA_FACTOR:     r_cfg.sigma_factor     <= pwdata[7:0];
                REG_AVERAGE_SIZE:     r_cfg.average_size     <= pwdata[4:0];
                REG_STATIONARY_SPEED: r_cfg.stationary_speed <= pwdata[14:0];
                REG_CALIBRATION_SIZE: r_cfg.calibration_size <= pwdata[7:0];
                REG_AUTO_CALIBRATION: r_cfg.auto_calibration <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    // Register reads.
    always_comb begin
        case (reg_sel)
            REG_WIN_LEN:          prdata = DATA_W'(r_cfg.win_len);
            REG_SIGMA_FACTOR:     prdata = DATA_W'(r_cfg.sigma_factor);
            REG_AVERAGE_SIZE:     prdata = DATA_W'(r_cfg.average_size);
            REG_STATIONARY_SPEED: prdata = DATA_W'(r_cfg.stationary_speed);
            REG_CALIBRATION_SIZE: prdata = DATA_W'(r_cfg.calibration_size);
            REG_AUTO_CALIBRATION: prdata = DATA_W'(r_cfg.auto_calibration);
            default:              prdata = '0;
        endcase
    end

    assign out_free = !r_out_valid || i_m_axis_tready;

    imu_osbf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .i_out_free (out_free),
        .i_stat     (stat),
        .o_ready    (o_s_axis_tready),
        .o_cmd      (cmd)
    );

    imu_osbf_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_cmd      (cmd),
        .i_tdata    (i_s_axis_tdata),
        .i_tuser    (i_s_axis_tuser[0]),
        .o_stat     (stat),
        .o_out_data (res_data),
        .o_out_user (res_user)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.out_load) begin
            r_out_data <= res_data;
            r_out_user <= res_user;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    // An accepted IMU sample keeps the input side closed while it is worked on.
    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && !i_s_axis_tuser[0]) |=> !o_s_axis_tready)
        else $error("input accepted while a sample is in progress");

    // A new result is only produced while the input side is closed.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.out_load) |-> !o_s_axis_tready)
        else $error("result loaded while idle");

    // The result register only fills when it is free or being drained.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.out_load) |-> (!r_out_valid || i_m_axis_tready))
        else $error("unread result overwritten");

endmodule
